>>> design/cafp_pkg.sv
package cafp_pkg;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_SECOND = 2'd1,
        PH_RECORD = 2'd2
    } phase_t;

    localparam logic [0:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [0:0] CFG_SYNC_SECOND = 1'b1;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h7A;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h65;

    localparam logic [3:0] NIB_CH0 = 4'h1;
    localparam logic [3:0] NIB_CH1 = 4'h2;
    localparam logic [3:0] NIB_CH2 = 4'h4;

    localparam logic [1:0] POS_HIGH   = 2'd0;
    localparam logic [1:0] POS_LOW    = 2'd1;
    localparam logic [1:0] POS_WEIGHT = 2'd2;
    localparam logic [1:0] POS_PARITY = 2'd3;

    typedef struct packed {
        logic [1:0]  channel;
        logic [11:0] value;
        logic        check_ok;
        logic        frame_end;
    } result_t;

endpackage

>>> design/checked_adc_frame_parser_unit.sv
// Frame parser for a checked ADC byte stream. One received byte is taken per
// cycle while the input is not stalled; a byte passes through the input
// register, and a record's result is presented from the result register. The
// input stalls only while a finished result waits to be taken. Sync bytes and
// the record bytes other than the last give no result. Each record of
// RECORDS_PER_FRAME per frame gives one result carrying the channel, its
// register value, whether the popcount and parity checks passed, and an
// end-of-frame flag on the last record. The user must write the sync bytes
// through the cfg port only while the stream is idle; nothing here enforces it.
module checked_adc_frame_parser_unit
    import cafp_pkg::*;
#(
    parameter int RECORDS_PER_FRAME = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  channel,
    output logic [11:0] value,
    output logic        check_ok,
    output logic        frame_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [1:0] LAST_RECORD = 2'(RECORDS_PER_FRAME - 1);

    logic [7:0]  sync_first_reg, sync_second_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    phase_t      phase_reg, phase_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [1:0]  record_index_reg, record_index_next;
    logic [1:0]  held_channel_reg, held_channel_next;
    logic [7:0]  held_high_reg, held_high_next;
    logic [7:0]  held_low_reg, held_low_next;
    logic [7:0]  held_weight_reg, held_weight_next;
    logic [11:0] channel_values_reg [3];
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;

    logic        advance;
    logic        process;
    logic        emit;
    logic        nib_ok;
    logic [1:0]  nib_channel;
    logic [4:0]  pop;
    logic [1:0]  par;
    logic        ok;
    logic [11:0] new_value;

    assign advance   = !out_valid_reg || !out_stall;
    assign process   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_valid_next = in_stall ? 1'b1 : in_valid;

    always_comb
    begin
        nib_ok      = 1'b1;
        nib_channel = 2'd0;
        case (in_byte_reg[7:4])
            NIB_CH0: nib_channel = 2'd0;
            NIB_CH1: nib_channel = 2'd1;
            NIB_CH2: nib_channel = 2'd2;
            default: nib_ok = 1'b0;
        endcase
    end

    // The check sees the popcount of both held bytes and the sum of their low bits.
    assign pop       = 5'($countones({held_high_reg, held_low_reg}));
    assign par       = {1'b0, held_high_reg[0]} + {1'b0, held_low_reg[0]};
    assign ok        = (held_weight_reg == {3'b000, pop}) && (in_byte_reg == {6'd0, par});
    assign new_value = {held_high_reg[3:0], held_low_reg};

    // Next state of the parser.
    always_comb
    begin
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        record_index_next = record_index_reg;
        held_channel_next = held_channel_reg;
        held_high_next    = held_high_reg;
        held_low_next     = held_low_reg;
        held_weight_next  = held_weight_reg;
        emit              = 1'b0;
        case (phase_reg)
            PH_SECOND:
            begin
                byte_pos_next     = POS_HIGH;
                record_index_next = 2'd0;
                if (in_byte_reg == sync_second_reg)
                    phase_next = PH_RECORD;
                else if (in_byte_reg == sync_first_reg)
                    phase_next = PH_SECOND;
                else
                    phase_next = PH_HUNT;
            end
            PH_RECORD:
            begin
                case (byte_pos_reg)
                    POS_HIGH:
                    begin
                        if (nib_ok)
                        begin
                            held_channel_next = nib_channel;
                            held_high_next    = in_byte_reg;
                            byte_pos_next     = POS_LOW;
                        end
                        else
                        begin
                            // A bad channel nibble drops the frame; the byte may start a new one.
                            phase_next        = (in_byte_reg == sync_first_reg) ? PH_SECOND
                                                                                : PH_HUNT;
                            byte_pos_next     = POS_HIGH;
                            record_index_next = 2'd0;
                        end
                    end
                    POS_LOW:
                    begin
                        held_low_next = in_byte_reg;
                        byte_pos_next = POS_WEIGHT;
                    end
                    POS_WEIGHT:
                    begin
                        held_weight_next = in_byte_reg;
                        byte_pos_next    = POS_PARITY;
                    end
                    default:
                    begin
                        emit          = 1'b1;
                        byte_pos_next = POS_HIGH;
                        if (record_index_reg == LAST_RECORD)
                        begin
                            phase_next        = PH_HUNT;
                            record_index_next = 2'd0;
                        end
                        else
                            record_index_next = record_index_reg + 2'd1;
                    end
                endcase
            end
            default:
            begin
                phase_next        = (in_byte_reg == sync_first_reg) ? PH_SECOND : PH_HUNT;
                byte_pos_next     = POS_HIGH;
                record_index_next = 2'd0;
            end
        endcase
    end

    // Result assembled from the held record and the parity byte.
    always_comb
    begin
        result_next.channel   = held_channel_reg;
        result_next.value     = ok ? new_value : channel_values_reg[held_channel_reg];
        result_next.check_ok  = ok;
        result_next.frame_end = (record_index_reg == LAST_RECORD);
        if (process)
            out_valid_next = emit;
        else if (advance)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg        <= SYNC_FIRST_RESET;
            sync_second_reg       <= SYNC_SECOND_RESET;
            in_valid_reg          <= 1'b0;
            phase_reg             <= PH_HUNT;
            byte_pos_reg          <= POS_HIGH;
            record_index_reg      <= 2'd0;
            held_channel_reg      <= 2'd0;
            held_high_reg         <= 8'd0;
            held_low_reg          <= 8'd0;
            held_weight_reg       <= 8'd0;
            channel_values_reg[0] <= 12'd0;
            channel_values_reg[1] <= 12'd0;
            channel_values_reg[2] <= 12'd0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index[1] == 1'b0)
            begin
                if (cfg_index[0] == CFG_SYNC_FIRST)
                    sync_first_reg <= cfg_data;
                else
                    sync_second_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                phase_reg        <= phase_next;
                byte_pos_reg     <= byte_pos_next;
                record_index_reg <= record_index_next;
                held_channel_reg <= held_channel_next;
                held_high_reg    <= held_high_next;
                held_low_reg     <= held_low_next;
                held_weight_reg  <= held_weight_next;
                if (emit && ok)
                    channel_values_reg[held_channel_reg] <= new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            in_byte_reg <= rx_byte;
        if (process && emit)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign channel   = result_reg.channel;
    assign value     = result_reg.value;
    assign check_ok  = result_reg.check_ok;
    assign frame_end = result_reg.frame_end;

endmodule

>>> design/cafp_checker.sv
module cafp_checker
    import cafp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  channel,
    input logic [11:0] value,
    input logic        check_ok,
    input logic        frame_end
);

    // The input side is held back only by a result that is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // A new result comes from an earlier byte transfer through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a preceding input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (channel != 2'd3))
        else $error("result names a channel that does not exist");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(channel) && $stable(value)
                                      && $stable(check_ok) && $stable(frame_end)))
        else $error("stalled result changed");

endmodule

bind checked_adc_frame_parser_unit cafp_checker u_cafp_checker (.*);
